/* hdl/stt_pkg.sv */
// Package for the software timer table: shared types, constants and helpers.
// Used by stt_cell and software_timer_table_unit; depends on nothing else.
package stt_pkg;

	localparam int TIME_W        = 31;
	localparam int HB_W          = 22;
	localparam int POLL_W        = 41;
	localparam int MS_W          = 10;
	localparam int SLOTS_DEF     = 16;
	localparam int KEY_BITS_DEF  = 16;

	localparam logic [TIME_W-1:0] TIME_SAT    = 31'h7FFF_FFFE;
	localparam logic [TIME_W-1:0] TIME_NONE   = 31'h7FFF_FFFF;
	localparam logic [MS_W-1:0]   MS_PER_UNIT = 10'd1000;
	localparam logic [HB_W-1:0]   HB_RESET    = 22'd60;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_FIRE  = 2'd2,
		OP_POLL  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPEND,
		S_DONE,
		S_FSCAN,
		S_FIRE,
		S_POLL,
		S_MUL
	} state_t;

	// Shift and load commands broadcast to every cell of the chain.
	typedef struct packed {
		logic pop;
		logic push;
	} cell_ctl_t;

	// Sum of two times, saturated at the largest valid deadline.
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, TIME_SAT}) ? TIME_SAT : s[TIME_W-1:0];
	endfunction

endpackage

/* hdl/stt_cell.sv */
// One slot of the timer chain: key, deadline and period of a single entry.
// Depends on stt_pkg; instantiated in a row by software_timer_table_unit.
module stt_cell import stt_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF,
	parameter int IDX_W    = 4,
	parameter int INDEX    = 0
) (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic [IDX_W-1:0]    wpos,
	input  logic [KEY_BITS-1:0] push_key,
	input  logic [TIME_W-1:0]   push_deadline,
	input  logic [TIME_W-1:0]   push_period,
	input  logic [KEY_BITS-1:0] nb_key,
	input  logic [TIME_W-1:0]   nb_deadline,
	input  logic [TIME_W-1:0]   nb_period,
	output logic [KEY_BITS-1:0] key,
	output logic [TIME_W-1:0]   deadline,
	output logic [TIME_W-1:0]   period
);

	logic [KEY_BITS-1:0] key_q;
	logic [TIME_W-1:0]   deadline_q;
	logic [TIME_W-1:0]   period_q;
	logic                sel;

	assign sel = ctl.push && (wpos == IDX_W'(INDEX));

	// A push into this slot wins over the shift from the upper neighbor.
	always_ff @(posedge clk) begin
		if (sel) begin
			key_q      <= push_key;
			deadline_q <= push_deadline;
			period_q   <= push_period;
		end else if (ctl.pop) begin
			key_q      <= nb_key;
			deadline_q <= nb_deadline;
			period_q   <= nb_period;
		end
	end

	assign key      = key_q;
	assign deadline = deadline_q;
	assign period   = period_q;

endmodule

/* hdl/software_timer_table_unit.sv */
// Top level of the software timer table: a chain of timer cells and its sequencer.
// Depends on stt_pkg and stt_cell.
//
// Usage: one input channel (in_valid/in_stall) carries an operation: set, clear,
// fire or poll. One output channel (out_valid/out_stall) returns its results.
// Set, clear and poll return one transaction; fire returns one transaction per
// expired timer (or one with fired_valid low when none expired), the final one
// marked by last. The user must write the heartbeat register through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce it.
// The entries live in a shift chain, and every pass pops the head entry and
// pushes it back at the tail unless it is dropped, one entry per cycle unless
// a fire pass holds for a stalled result. A set scans the chain, dropping any
// entry with its key, and then appends the new entry; a clear only scans. A
// poll computes the time left and then multiplies it by MS_PER_UNIT. A fire
// first scans the chain; if any timer expired, a second pass updates the
// table and reports each expired key.
// The block takes a new operation once the previous one has finished; its
// last result may still be waiting in the output register.
// Reset empties the table, clears the earliest deadline and sets the
// heartbeat to 60. A stalled receiver freezes the output register, and a fire
// pass holds at the next expired entry until the register frees up.
module software_timer_table_unit import stt_pkg::*; #(
	parameter int TIMER_SLOTS = SLOTS_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [HB_W-1:0]     cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic [TIME_W-1:0]   now_time,
	input  logic [KEY_BITS-1:0] timer_key,
	input  logic [TIME_W-1:0]   delay,
	input  logic [TIME_W-1:0]   period,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [KEY_BITS-1:0] fired_key,
	output logic                fired_valid,
	output logic [POLL_W-1:0]   poll_timeout,
	output logic [TIME_W-1:0]   next_deadline,
	output logic                status,
	output logic                last
);

	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	// Chain wiring.
	logic [KEY_BITS-1:0] c_key [TIMER_SLOTS];
	logic [TIME_W-1:0]   c_dl  [TIMER_SLOTS];
	logic [TIME_W-1:0]   c_per [TIMER_SLOTS];
	cell_ctl_t           ctl;
	logic [IDX_W-1:0]    wpos;
	logic [KEY_BITS-1:0] p_key;
	logic [TIME_W-1:0]   p_dl;
	logic [TIME_W-1:0]   p_per;

	genvar gi;
	generate
		for (gi = 0; gi < TIMER_SLOTS; gi++) begin : g_cell
			logic [KEY_BITS-1:0] nb_key;
			logic [TIME_W-1:0]   nb_dl;
			logic [TIME_W-1:0]   nb_per;
			if (gi == TIMER_SLOTS - 1) begin : g_top
				assign nb_key = '0;
				assign nb_dl  = '0;
				assign nb_per = '0;
			end else begin : g_mid
				assign nb_key = c_key[gi+1];
				assign nb_dl  = c_dl[gi+1];
				assign nb_per = c_per[gi+1];
			end
			stt_cell #(
				.KEY_BITS(KEY_BITS),
				.IDX_W   (IDX_W),
				.INDEX   (gi)
			) u_cell (
				.clk          (clk),
				.ctl          (ctl),
				.wpos         (wpos),
				.push_key     (p_key),
				.push_deadline(p_dl),
				.push_period  (p_per),
				.nb_key       (nb_key),
				.nb_deadline  (nb_dl),
				.nb_period    (nb_per),
				.key          (c_key[gi]),
				.deadline     (c_dl[gi]),
				.period       (c_per[gi])
			);
		end
	endgenerate

	// Control and working registers.
	state_t              state_q, state_d;
	op_t                 op_q, op_d;
	logic [TIME_W-1:0]   now_q, now_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	logic [TIME_W-1:0]   delay_q, delay_d;
	logic [TIME_W-1:0]   per_q, per_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [CNT_W-1:0]    step_q, step_d;
	logic [CNT_W-1:0]    rem_q, rem_d;
	logic [CNT_W-1:0]    ftot_q, ftot_d;
	logic [CNT_W-1:0]    fleft_q, fleft_d;
	logic [TIME_W-1:0]   min_q, min_d;
	logic [TIME_W-1:0]   nd_q, nd_d;
	logic [TIME_W-1:0]   ed_q, ed_d;
	logic [TIME_W-1:0]   t_q, t_d;
	logic                stat_q, stat_d;
	logic [HB_W-1:0]     hb_q;

	// Output register.
	logic                o_valid_q;
	logic [KEY_BITS-1:0] o_key_q, o_key_d;
	logic                o_fv_q, o_fv_d;
	logic [POLL_W-1:0]   o_poll_q, o_poll_d;
	logic [TIME_W-1:0]   o_nd_q, o_nd_d;
	logic                o_stat_q, o_stat_d;
	logic                o_last_q, o_last_d;
	logic                o_load;
	logic                out_can;

	// Head of the chain and the values derived from it.
	logic [KEY_BITS-1:0] h_key;
	logic [TIME_W-1:0]   h_dl;
	logic [TIME_W-1:0]   h_per;
	logic                h_fires;
	logic [TIME_W-1:0]   h_next;
	logic [TIME_W-1:0]   new_dl;
	logic [CNT_W-1:0]    cnt_m1;
	logic [POLL_W-1:0]   poll_prod;
	logic                in_acc;

	assign h_key   = c_key[0];
	assign h_dl    = c_dl[0];
	assign h_per   = c_per[0];
	assign h_fires = (h_dl <= now_q);
	assign h_next  = sat_add(h_dl, h_per);
	assign new_dl  = sat_add(now_q, delay_q);
	assign cnt_m1  = cnt_q - CNT_W'(1);
	assign wpos    = ctl.pop ? cnt_m1[IDX_W-1:0] : cnt_q[IDX_W-1:0];
	assign poll_prod = t_q * MS_PER_UNIT;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_can  = !o_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		now_d    = now_q;
		key_d    = key_q;
		delay_d  = delay_q;
		per_d    = per_q;
		cnt_d    = cnt_q;
		step_d   = step_q;
		rem_d    = rem_q;
		ftot_d   = ftot_q;
		fleft_d  = fleft_q;
		min_d    = min_q;
		nd_d     = nd_q;
		ed_d     = ed_q;
		t_d      = t_q;
		stat_d   = stat_q;
		ctl      = '0;
		p_key    = h_key;
		p_dl     = h_dl;
		p_per    = h_per;
		o_load   = 1'b0;
		o_key_d  = '0;
		o_fv_d   = 1'b0;
		o_poll_d = '0;
		o_nd_d   = ed_q;
		o_stat_d = 1'b0;
		o_last_d = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					op_d    = op_t'(opcode);
					now_d   = now_time;
					key_d   = timer_key;
					delay_d = delay;
					per_d   = period;
					step_d  = cnt_q;
					rem_d   = '0;
					ftot_d  = '0;
					min_d   = TIME_NONE;
					stat_d  = 1'b0;
					case (op_t'(opcode))
						OP_SET:   state_d = S_SCAN;
						OP_CLEAR: state_d = S_SCAN;
						OP_FIRE:  state_d = S_FSCAN;
						OP_POLL:  state_d = S_POLL;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				// Drop the entry whose key matches, recirculate the rest.
				if (step_q != '0) begin
					ctl.pop = 1'b1;
					step_d  = step_q - CNT_W'(1);
					if (h_key != key_q) begin
						ctl.push = 1'b1;
						if (h_dl < min_q) begin
							min_d = h_dl;
						end
					end else begin
						cnt_d = cnt_m1;
					end
				end else if (op_q == OP_SET) begin
					state_d = S_APPEND;
				end else begin
					state_d = S_DONE;
				end
			end
			S_APPEND: begin
				if (cnt_q < CNT_W'(TIMER_SLOTS)) begin
					ctl.push = 1'b1;
					p_key    = key_q;
					p_dl     = new_dl;
					p_per    = per_q;
					cnt_d    = cnt_q + CNT_W'(1);
					if (new_dl < min_q) begin
						min_d = new_dl;
					end
				end else begin
					stat_d = 1'b1;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_can) begin
					o_load   = 1'b1;
					o_nd_d   = (cnt_q == '0) ? '0 : min_q;
					o_stat_d = stat_q;
					ed_d     = o_nd_d;
					state_d  = S_IDLE;
				end
			end
			S_FSCAN: begin
				// First pass: count expirations and find the resulting minimum
				// without changing the table.
				if (step_q != '0) begin
					ctl.pop  = 1'b1;
					ctl.push = 1'b1;
					step_d   = step_q - CNT_W'(1);
					if (h_fires) begin
						ftot_d = ftot_q + CNT_W'(1);
						if (h_per != '0) begin
							rem_d = rem_q + CNT_W'(1);
							if (h_next < min_q) begin
								min_d = h_next;
							end
						end
					end else begin
						rem_d = rem_q + CNT_W'(1);
						if (h_dl < min_q) begin
							min_d = h_dl;
						end
					end
				end else if (ftot_q == '0) begin
					state_d = S_DONE;
				end else begin
					step_d  = cnt_q;
					fleft_d = ftot_q;
					nd_d    = (rem_q == '0) ? '0 : min_q;
					state_d = S_FIRE;
				end
			end
			S_FIRE: begin
				// Second pass: update the table and report each expired key.
				if (step_q == '0) begin
					state_d = S_IDLE;
				end else if (!h_fires) begin
					ctl.pop  = 1'b1;
					ctl.push = 1'b1;
					step_d   = step_q - CNT_W'(1);
				end else if (out_can) begin
					ctl.pop  = 1'b1;
					step_d   = step_q - CNT_W'(1);
					fleft_d  = fleft_q - CNT_W'(1);
					o_load   = 1'b1;
					o_key_d  = h_key;
					o_fv_d   = 1'b1;
					o_nd_d   = nd_q;
					o_last_d = (fleft_q == CNT_W'(1));
					ed_d     = nd_q;
					if (h_per != '0) begin
						ctl.push = 1'b1;
						p_dl     = h_next;
					end else begin
						cnt_d = cnt_m1;
					end
				end
			end
			S_POLL: begin
				if (cnt_q == '0) begin
					t_d = TIME_W'(hb_q);
				end else if (ed_q > now_q) begin
					t_d = ed_q - now_q;
				end else begin
					t_d = '0;
				end
				state_d = S_MUL;
			end
			S_MUL: begin
				if (out_can) begin
					o_load   = 1'b1;
					o_poll_d = poll_prod;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			ed_q      <= '0;
			hb_q      <= HB_RESET;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ed_q    <= ed_d;
			if (cfg_wr_en) begin
				hb_q <= cfg_wr_data;
			end
			if (o_load) begin
				o_valid_q <= 1'b1;
			end else if (!out_stall) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q    <= op_d;
		now_q   <= now_d;
		key_q   <= key_d;
		delay_q <= delay_d;
		per_q   <= per_d;
		step_q  <= step_d;
		rem_q   <= rem_d;
		ftot_q  <= ftot_d;
		fleft_q <= fleft_d;
		min_q   <= min_d;
		nd_q    <= nd_d;
		t_q     <= t_d;
		stat_q  <= stat_d;
		if (o_load) begin
			o_key_q  <= o_key_d;
			o_fv_q   <= o_fv_d;
			o_poll_q <= o_poll_d;
			o_nd_q   <= o_nd_d;
			o_stat_q <= o_stat_d;
			o_last_q <= o_last_d;
		end
	end

	assign out_valid     = o_valid_q;
	assign fired_key     = o_key_q;
	assign fired_valid   = o_fv_q;
	assign poll_timeout  = o_poll_q;
	assign next_deadline = o_nd_q;
	assign status        = o_stat_q;
	assign last          = o_last_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TIMER_SLOTS))
		else $error("entry count exceeds the table size");

	a_fire_all_sent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIRE && step_q == '0) |-> fleft_q == '0)
		else $error("fire pass ended with expired keys not reported");

	a_nonlast_in_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && !o_last_q) |-> state_q == S_FIRE)
		else $error("non-final result outside a fire pass");

	a_append_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPEND) |-> step_q == '0)
		else $error("append before the scan finished");
`endif

endmodule

/* dv/tb_software_timer_table_unit.sv */
// Self-checking testbench for software_timer_table_unit: directed and random
// set/clear/fire/poll traffic checked against a behavioral timer-table predictor.
// Depends on stt_pkg and the RTL of the block; reads no files.
module tb_software_timer_table_unit;
	import stt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;

	// One expected result transaction.
	typedef struct {
		logic [15:0]       key;
		logic              fvalid;
		logic [POLL_W-1:0] poll;
		logic [TIME_W-1:0] nxt;
		logic              stat;
		logic              lst;
	} timer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [HB_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = OP_POLL;
	logic [TIME_W-1:0] now_time = '0;
	logic [15:0] timer_key = '0;
	logic [TIME_W-1:0] delay = '0;
	logic [TIME_W-1:0] period = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] fired_key;
	logic fired_valid;
	logic [POLL_W-1:0] poll_timeout;
	logic [TIME_W-1:0] next_deadline;
	logic status;
	logic last;

	software_timer_table_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .now_time(now_time), .timer_key(timer_key),
		.delay(delay), .period(period),
		.out_valid(out_valid), .out_stall(out_stall),
		.fired_key(fired_key), .fired_valid(fired_valid),
		.poll_timeout(poll_timeout), .next_deadline(next_deadline),
		.status(status), .last(last)
	);

	// Predictor state: a private copy of the timer table.
	logic [15:0]       tbl_key [SLOTS];
	logic [TIME_W-1:0] tbl_dl  [SLOTS];
	logic [TIME_W-1:0] tbl_per [SLOTS];
	int                tbl_count = 0;
	logic [TIME_W-1:0] tbl_earliest = '0;
	logic [HB_W-1:0]   hb_value = HB_RESET;

	timer_result_t pending_results[$];
	int  error_count = 0;
	int  items_sent = 0;
	int  results_seen = 0;
	int  fired_seen = 0;
	bit  idle_enabled = 1'b1;
	logic [TIME_W-1:0] clock_now = '0;

	initial forever #5 clk = ~clk;

	// Generous global limit; the slowest correct run is far shorter.
	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > 32'h7FFF_FFFE) return 31'h7FFF_FFFE;
		return s[TIME_W-1:0];
	endfunction

	function automatic void drop_slot(int i);
		for (int j = i; j < tbl_count - 1; j++) begin
			tbl_key[j] = tbl_key[j+1];
			tbl_dl[j]  = tbl_dl[j+1];
			tbl_per[j] = tbl_per[j+1];
		end
		tbl_count--;
	endfunction

	function automatic int slot_of(logic [15:0] k);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void refresh_earliest();
		logic [TIME_W-1:0] m;
		m = 31'h7FFF_FFFF;
		for (int i = 0; i < tbl_count; i++)
			if (tbl_dl[i] < m) m = tbl_dl[i];
		tbl_earliest = (tbl_count == 0) ? '0 : m;
	endfunction

	// Applies one operation to the table copy and queues its results.
	function automatic void predict_timer_op(logic [1:0] op, logic [TIME_W-1:0] now,
			logic [15:0] k, logic [TIME_W-1:0] dly, logic [TIME_W-1:0] per);
		timer_result_t r;
		logic [15:0] fired[$];
		int idx;
		int i;
		r = '{key: '0, fvalid: 1'b0, poll: '0, nxt: '0, stat: 1'b0, lst: 1'b1};
		case (op)
			OP_SET: begin
				idx = slot_of(k);
				if (idx >= 0) drop_slot(idx);
				if (tbl_count < SLOTS) begin
					tbl_key[tbl_count] = k;
					tbl_dl[tbl_count]  = sat_sum(now, dly);
					tbl_per[tbl_count] = per;
					tbl_count++;
				end else begin
					r.stat = 1'b1;
				end
				refresh_earliest();
				r.nxt = tbl_earliest;
				pending_results = {pending_results, r};
			end
			OP_CLEAR: begin
				idx = slot_of(k);
				if (idx >= 0) drop_slot(idx);
				refresh_earliest();
				r.nxt = tbl_earliest;
				pending_results = {pending_results, r};
			end
			OP_FIRE: begin
				i = 0;
				while (i < tbl_count) begin
					if (tbl_dl[i] <= now) begin
						fired = {fired, tbl_key[i]};
						if (tbl_per[i] != 0) begin
							tbl_dl[i] = sat_sum(tbl_dl[i], tbl_per[i]);
							i++;
						end else begin
							drop_slot(i);
						end
					end else begin
						i++;
					end
				end
				refresh_earliest();
				r.nxt = tbl_earliest;
				if (fired.size() == 0) begin
					pending_results = {pending_results, r};
				end else begin
					foreach (fired[n]) begin
						r.key = fired[n];
						r.fvalid = 1'b1;
						r.lst = (n == fired.size() - 1);
						pending_results = {pending_results, r};
					end
				end
			end
			default: begin
				refresh_earliest();
				r.nxt = tbl_earliest;
				if (tbl_count == 0)
					r.poll = POLL_W'(hb_value) * 1000;
				else if (tbl_earliest > now)
					r.poll = POLL_W'(tbl_earliest - now) * 1000;
				pending_results = {pending_results, r};
			end
		endcase
	endfunction

	// Receiver: random stall, compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		timer_result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result key=%h", $time, fired_key);
					error_count++;
				end else begin
					e = pending_results.pop_front();
					if (fired_valid) fired_seen++;
					if (fired_key !== e.key || fired_valid !== e.fvalid ||
							poll_timeout !== e.poll || next_deadline !== e.nxt ||
							status !== e.stat || last !== e.lst) begin
						$display("%0t: mismatch expected key=%h fv=%b poll=%0d nd=%0d st=%b last=%b",
							$time, e.key, e.fvalid, e.poll, e.nxt, e.stat, e.lst);
						$display("%0t:          actual   key=%h fv=%b poll=%0d nd=%0d st=%b last=%b",
							$time, fired_key, fired_valid, poll_timeout, next_deadline,
							status, last);
						error_count++;
					end
				end
			end
			out_stall <= idle_enabled ? ($urandom_range(99) < 38) : 1'b0;
		end
	end

	// Sends one operation, idling at random beforehand, and predicts its results.
	// Valid stays high after the handshake so that a following operation can be
	// driven at the same edge; an idle gap or a drain drops it.
	task automatic send_op(logic [1:0] op, logic [TIME_W-1:0] now, logic [15:0] k,
			logic [TIME_W-1:0] dly, logic [TIME_W-1:0] per);
		if (idle_enabled && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 38);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		now_time  <= now;
		timer_key <= k;
		delay     <= dly;
		period    <= per;
		do @(posedge clk); while (in_stall);
		predict_timer_op(op, now, k, dly, per);
		items_sent++;
	endtask

	// Waits for every expected result, then lets the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_heartbeat(logic [HB_W-1:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		hb_value = v;
	endtask

	// Moves the shared clock on by a random, mostly small amount.
	function automatic logic [TIME_W-1:0] advance(int max_step);
		logic [TIME_W:0] s;
		s = {1'b0, clock_now} + $urandom_range(max_step);
		clock_now = (s > 32'h7FFF_FFFE) ? 31'h7FFF_FFFE : s[TIME_W-1:0];
		return clock_now;
	endfunction

	// Empty table: poll reports the heartbeat, fire reports nothing, clear of an
	// absent key does nothing; the heartbeat register is swept to its extremes.
	task automatic test_empty_table();
		send_op(OP_POLL, 0, 0, 0, 0);
		send_op(OP_FIRE, 0, 0, 0, 0);
		send_op(OP_CLEAR, 0, 16'hFFFF, 0, 0);
		write_heartbeat('0);
		send_op(OP_POLL, 5, 0, 0, 0);
		write_heartbeat(22'h3FFFFF);
		send_op(OP_POLL, 5, 0, 0, 0);
		write_heartbeat(22'd2147483 & 22'h3FFFFF);
		send_op(OP_POLL, 5, 0, 0, 0);
	endtask

	// Zero deadline, saturated sums, replacement of an existing key and a late
	// periodic timer that fires only once per fire operation.
	task automatic test_deadline_edges();
		send_op(OP_SET, 0, 16'h0000, 0, 0);
		send_op(OP_SET, 31'h7FFF_FFFE, 16'hFFFF, 31'h7FFF_FFFE, 31'h7FFF_FFFE);
		send_op(OP_SET, 10, 16'h5555, 3, 1);
		send_op(OP_SET, 10, 16'hAAAA, 100, 0);
		send_op(OP_SET, 10, 16'h5555, 2, 1);
		send_op(OP_POLL, 0, 0, 0, 0);
		send_op(OP_FIRE, 50, 0, 0, 0);
		send_op(OP_POLL, 200, 0, 0, 0);
		send_op(OP_FIRE, 31'h7FFF_FFFE, 0, 0, 0);
		send_op(OP_CLEAR, 0, 16'hFFFF, 0, 0);
		send_op(OP_CLEAR, 0, 16'h5555, 0, 0);
		drain();
	endtask

	// Fills the table, is refused one more key, then fires every slot at once.
	task automatic test_full_table();
		for (int i = 0; i < SLOTS; i++)
			send_op(OP_SET, 1000, 16'(i + 1), 31'(i), (i % 2) ? 31'd7 : 31'd0);
		send_op(OP_SET, 1000, 16'h7777, 5, 0);
		send_op(OP_SET, 1000, 16'd3, 1, 0);
		send_op(OP_FIRE, 2000, 0, 0, 0);
		clock_now = 2000;
	endtask

	// Random traffic over a small key space so replacements and clears hit,
	// with a stretch without any idling and a pause until all results arrive.
	task automatic test_random_traffic(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			if (i == n / 3) idle_enabled = 1'b0;
			if (i == n / 2) begin
				idle_enabled = 1'b1;
				drain();
				write_heartbeat(22'($urandom));
			end
			r = $urandom_range(99);
			if (r < 40)
				send_op(OP_SET, advance(20), ($urandom_range(3) == 0) ? 16'($urandom)
					: 16'($urandom_range(19)),
					($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(60)),
					($urandom_range(2) == 0) ? 31'd0 : (($urandom_range(9) == 0)
					? 31'($urandom) : 31'($urandom_range(1, 40))));
			else if (r < 55)
				send_op(OP_CLEAR, advance(20), 16'($urandom_range(19)), 31'($urandom),
					31'($urandom));
			else if (r < 85)
				send_op(OP_FIRE, advance(40), 16'($urandom), 31'($urandom), 31'($urandom));
			else
				send_op(OP_POLL, advance(20), 16'($urandom), 31'($urandom), 31'($urandom));
		end
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_deadline_edges();
		test_full_table();
		test_random_traffic(174);
		$display("Covered %0d operations and %0d results, %0d of them fired timers.",
			items_sent, results_seen, fired_seen);
		$display("Heartbeat swept 0 to max; full table, saturation and replacement exercised.");
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
